@@ design/mccled_pkg.sv @@
package mccled_pkg;

  // One control-change message
  typedef struct packed {
    logic [6:0] controller;
    logic [6:0] cc_value;
  } cc_item_t;

  // One LED parameter write
  typedef struct packed {
    logic [1:0]  led_index;
    logic [2:0]  target_field;
    logic [13:0] field_value;
  } led_write_t;

  // Parameter codes carried in target_field
  typedef enum logic [2:0] {
    FIELD_BRIGHT1 = 3'd0,
    FIELD_TIME1   = 3'd1,
    FIELD_GLIDE1  = 3'd2,
    FIELD_BRIGHT2 = 3'd3,
    FIELD_TIME2   = 3'd4,
    FIELD_GLIDE2  = 3'd5,
    FIELD_BLINK   = 3'd6,
    FIELD_SIMPLE  = 3'd7
  } field_e;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_MODE         = 3'd0,
    REG_LED0_SIMPLE  = 3'd1,
    REG_LED1_SIMPLE  = 3'd2,
    REG_LED2_SIMPLE  = 3'd3,
    REG_LED0_BASE    = 3'd4,
    REG_LED1_BASE    = 3'd5,
    REG_LED2_BASE    = 3'd6,
    REG_UNUSED       = 3'd7
  } cfg_reg_e;

  localparam int unsigned LedCount   = 3;
  localparam int unsigned CtrlWidth  = 7;
  localparam int unsigned CtrlCount  = 1 << CtrlWidth;
  localparam logic [6:0]  LsbOffset  = 7'd32;
  localparam logic [2:0]  LastOffset = 3'd6;

  // Reset values of the controller registers
  localparam logic [6:0] SimpleRst0 = 7'd20;
  localparam logic [6:0] SimpleRst1 = 7'd21;
  localparam logic [6:0] SimpleRst2 = 7'd22;
  localparam logic [6:0] BaseRst0   = 7'd0;
  localparam logic [6:0] BaseRst1   = 7'd7;
  localparam logic [6:0] BaseRst2   = 7'd14;

  // Reciprocal of 127 folded with the factor 1000, applied as >> 24
  localparam logic [33:0] ScaleMul   = 34'd132105000;
  localparam int unsigned ScaleShift = 24;

  typedef struct packed {
    logic                  operating_mode;
    logic [2:0][6:0]       simple_ctrl;
    logic [2:0][6:0]       base_ctrl;
  } cfg_regs_t;

  // Decode outcome for one item
  typedef struct packed {
    logic       emit;
    led_write_t result;
    logic       msb_write;
    logic       clear_valid;
  } dec_out_t;

  // value * 1000 / 127 for a 7-bit value, exact over 0..127
  function automatic logic [9:0] scale_brightness(input logic [6:0] v);
    logic [33:0] prod;
    prod = 34'(v) * ScaleMul;
    return prod[ScaleShift +: 10];
  endfunction

  // Time and glide parameters are 14-bit, sent as MSB then LSB
  function automatic logic is_wide(input logic [2:0] p);
    return (p == FIELD_TIME1) || (p == FIELD_GLIDE1) ||
           (p == FIELD_TIME2) || (p == FIELD_GLIDE2);
  endfunction

endpackage

@@ design/mccled_decode.sv @@
module mccled_decode (
  input  mccled_pkg::cc_item_t  item_i,
  input  mccled_pkg::cfg_regs_t cfg_i,
  input  logic                  lsb_pending_i,
  input  logic [6:0]            lsb_msb_i,
  output mccled_pkg::dec_out_t  dec_o
);

  logic [2:0]      msb_hit;
  logic [2:0]      lsb_hit;
  logic [2:0][2:0] msb_off;
  logic [2:0][2:0] lsb_off;
  logic [9:0]      scaled;

  assign scaled = mccled_pkg::scale_brightness(item_i.cc_value);

  // Match the controller against each LED's MSB and LSB ranges
  always_comb begin
    logic [7:0] dm;
    logic [8:0] lo;
    logic [8:0] dl;
    for (int i = 0; i < 3; i++) begin
      dm = {1'b0, item_i.controller} - {1'b0, cfg_i.base_ctrl[i]};
      msb_hit[i] = !dm[7] && (dm[6:0] <= 7'(mccled_pkg::LastOffset));
      msb_off[i] = dm[2:0];
      lo = {2'b00, cfg_i.base_ctrl[i]} + {2'b00, mccled_pkg::LsbOffset};
      dl = {2'b00, item_i.controller} - lo;
      lsb_hit[i] = !dl[8] && (dl[7:0] <= 8'(mccled_pkg::LastOffset));
      lsb_off[i] = dl[2:0];
    end
  end

  // Pick the first match and form the result
  always_comb begin
    logic found;
    found = 1'b0;
    dec_o = '0;
    if (!cfg_i.operating_mode) begin
      for (int i = 0; i < 3; i++) begin
        if (!found && item_i.controller == cfg_i.simple_ctrl[i]) begin
          found = 1'b1;
          dec_o.emit = 1'b1;
          dec_o.result.led_index = 2'(i);
          dec_o.result.target_field = mccled_pkg::FIELD_SIMPLE;
          dec_o.result.field_value = {4'b0, scaled};
        end
      end
    end else begin
      for (int i = 0; i < 3; i++) begin
        if (!found && msb_hit[i]) begin
          found = 1'b1;
          dec_o.result.led_index = 2'(i);
          dec_o.result.target_field = msb_off[i];
          if (mccled_pkg::is_wide(msb_off[i])) begin
            dec_o.msb_write = 1'b1;
          end else if (msb_off[i] == mccled_pkg::FIELD_BLINK) begin
            dec_o.emit = 1'b1;
            dec_o.result.field_value = {7'b0, item_i.cc_value};
          end else begin
            dec_o.emit = 1'b1;
            dec_o.result.field_value = {4'b0, scaled};
          end
        end
      end
      for (int i = 0; i < 3; i++) begin
        if (!found && lsb_hit[i]) begin
          found = 1'b1;
          dec_o.result.led_index = 2'(i);
          dec_o.result.target_field = lsb_off[i];
          dec_o.result.field_value = {lsb_msb_i, item_i.cc_value};
          // Drop an LSB with no stored MSB; consume the MSB otherwise
          if (lsb_pending_i) begin
            dec_o.clear_valid = 1'b1;
            dec_o.emit = mccled_pkg::is_wide(lsb_off[i]);
          end
        end
      end
    end
  end

endmodule

@@ design/midi_cc_led_parameter_decoder.sv @@
// MIDI control-change to LED parameter decoder. Takes one control-change item
// per cycle and gives at most one LED parameter write per item, registered in
// the input stage and then the output register; only out_ready_i low stalls
// the flow. In simple mode one controller per LED sets brightness 1 to
// value*1000/127 with all other parameters cleared (target field 7). In
// advanced mode each LED owns seven controllers from its base; 14-bit time and
// glide take the MSB on the controller and the LSB on controller+32, the MSB
// held in a 128-entry single-port-write, single-port-read RAM with per-entry
// valid flags and a forward path for back-to-back items. Writing the mode
// register clears all pending MSBs; configure only while the block is idle.
module midi_cc_led_parameter_decoder (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  mccled_pkg::cc_item_t   in_item_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output mccled_pkg::led_write_t out_item_o,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [2:0]             cfg_index_i,
  input  logic [6:0]             cfg_data_i
);

  mccled_pkg::cfg_regs_t   cfg_q;
  logic                    cfg_we;
  logic                    s1_valid_q;
  mccled_pkg::cc_item_t    s1_item_q;
  logic                    s1_fire;
  logic                    in_fire;
  logic                    out_valid_q;
  mccled_pkg::led_write_t  out_item_q;
  logic [mccled_pkg::CtrlCount-1:0] pend_valid_q;
  logic [6:0]              msb_mem [mccled_pkg::CtrlCount];
  logic [6:0]              mem_rd_q;
  logic                    byp_q;
  logic [6:0]              byp_data_q;
  logic [6:0]              rd_addr;
  logic [6:0]              lsb_slot;
  logic [6:0]              s1_msb;
  logic                    mem_we;
  mccled_pkg::dec_out_t    dec;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.operating_mode <= 1'b0;
      cfg_q.simple_ctrl[0] <= mccled_pkg::SimpleRst0;
      cfg_q.simple_ctrl[1] <= mccled_pkg::SimpleRst1;
      cfg_q.simple_ctrl[2] <= mccled_pkg::SimpleRst2;
      cfg_q.base_ctrl[0]   <= mccled_pkg::BaseRst0;
      cfg_q.base_ctrl[1]   <= mccled_pkg::BaseRst1;
      cfg_q.base_ctrl[2]   <= mccled_pkg::BaseRst2;
    end else if (cfg_we) begin
      unique case (mccled_pkg::cfg_reg_e'(cfg_index_i))
        mccled_pkg::REG_MODE:        cfg_q.operating_mode <= cfg_data_i[0];
        mccled_pkg::REG_LED0_SIMPLE: cfg_q.simple_ctrl[0] <= cfg_data_i;
        mccled_pkg::REG_LED1_SIMPLE: cfg_q.simple_ctrl[1] <= cfg_data_i;
        mccled_pkg::REG_LED2_SIMPLE: cfg_q.simple_ctrl[2] <= cfg_data_i;
        mccled_pkg::REG_LED0_BASE:   cfg_q.base_ctrl[0]   <= cfg_data_i;
        mccled_pkg::REG_LED1_BASE:   cfg_q.base_ctrl[1]   <= cfg_data_i;
        mccled_pkg::REG_LED2_BASE:   cfg_q.base_ctrl[2]   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Handshake: stage advances when the output register is free or drains
  assign s1_fire    = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_fire;
  assign in_fire    = in_valid_i && in_ready_o;

  // Input stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_fire) begin
      s1_valid_q <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_item_q <= in_item_i;
    end
  end

  // MSB store: read the LSB's partner slot on accept, forward a same-cycle write
  assign rd_addr  = in_item_i.controller - mccled_pkg::LsbOffset;
  assign lsb_slot = s1_item_q.controller - mccled_pkg::LsbOffset;
  assign mem_we   = s1_fire && dec.msb_write;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      msb_mem[s1_item_q.controller] <= s1_item_q.cc_value;
    end
    if (in_fire) begin
      mem_rd_q   <= msb_mem[rd_addr];
      byp_data_q <= s1_item_q.cc_value;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byp_q <= 1'b0;
    end else if (in_fire) begin
      byp_q <= mem_we && (s1_item_q.controller == rd_addr);
    end
  end

  assign s1_msb = byp_q ? byp_data_q : mem_rd_q;

  // Pending flags: set on MSB, clear on consumed LSB, wipe on mode write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_valid_q <= '0;
    end else if (cfg_we && cfg_index_i == mccled_pkg::REG_MODE) begin
      pend_valid_q <= '0;
    end else if (s1_fire) begin
      if (dec.msb_write) begin
        pend_valid_q[s1_item_q.controller] <= 1'b1;
      end else if (dec.clear_valid) begin
        pend_valid_q[lsb_slot] <= 1'b0;
      end
    end
  end

  mccled_decode u_decode (
    .item_i        (s1_item_q),
    .cfg_i         (cfg_q),
    .lsb_pending_i (pend_valid_q[lsb_slot]),
    .lsb_msb_i     (s1_msb),
    .dec_o         (dec)
  );

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_fire) begin
      out_valid_q <= dec.emit;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire && dec.emit) begin
      out_item_q <= dec.result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule
